>>> hw/rtl/rep_pkg.sv
// Shared types and constants for the rotary encoder panel decoder.
package rep_pkg;

    // Detent counter width; the reported position is its low 16 bits.
    localparam int COUNT_W    = 16;
    localparam int POS_W      = 16;
    localparam int TIME_W     = 32;
    localparam int LOCKOUT_W  = 10;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = LOCKOUT_W'(50);
    localparam logic [1:0]           MENU_LAST     = 2'd2;

    // Event kinds carried in the opcode field.
    typedef enum logic [1:0] {
        OP_MENU     = 2'd0,
        OP_BUTTON   = 2'd1,
        OP_ENC_EDGE = 2'd2
    } t_opcode;

    // Count change reported with each result.
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    // One accepted panel event.
    typedef struct packed {
        logic [1:0]        opcode;
        logic              a_level;
        logic              b_level;
        logic [TIME_W-1:0] now_ms;
    } t_event;

    // One result item.
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [1:0]              step_dir;
        logic [1:0]              menu_index;
        logic                    running;
    } t_result;

endpackage

>>> hw/rtl/rep_intf.sv
// Valid/ready channel interfaces for events, results and the lockout register.
interface rep_in_if import rep_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic              a_level;
    logic              b_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, opcode, a_level, b_level, now_ms, input ready);
    modport sink   (input valid, opcode, a_level, b_level, now_ms, output ready);
endinterface

interface rep_out_if import rep_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;
    logic [1:0]              step_dir;
    logic [1:0]              menu_index;
    logic                    running;

    modport source (output valid, position, step_dir, menu_index, running, input ready);
    modport sink   (input valid, position, step_dir, menu_index, running, output ready);
endinterface

interface rep_cfg_if import rep_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [LOCKOUT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/rep_core.sv
// Decoder state and the single-pass update for one registered event.
module rep_core import rep_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_commit,
    input  t_event               i_event,
    input  logic [LOCKOUT_W-1:0] i_lockout_ms,
    output t_result              o_result
);

    logic               r_armed,    n_armed;
    logic               r_latch_b,  n_latch_b;
    logic [COUNT_W-1:0] r_count,    n_count;
    logic [TIME_W-1:0]  r_last,     n_last;
    logic [1:0]         r_menu,     n_menu;
    logic               r_run,      n_run;
    t_dir               dir;
    logic [TIME_W-1:0]  elapsed;
    logic               edge_open;

    // Wrapping time since the last count, compared against the lockout.
    assign elapsed   = i_event.now_ms - r_last;
    assign edge_open = (elapsed >= TIME_W'(i_lockout_ms));

    // Next state for the event held in the input register.
    always_comb begin
        n_armed   = r_armed;
        n_latch_b = r_latch_b;
        n_count   = r_count;
        n_last    = r_last;
        n_menu    = r_menu;
        n_run     = r_run;
        dir       = DIR_NONE;
        case (i_event.opcode)
            OP_MENU: begin
                n_menu = (r_menu < MENU_LAST) ? r_menu + 2'd1 : 2'd0;
            end
            OP_BUTTON: begin
                n_run = ~r_run;
            end
            OP_ENC_EDGE: begin
                if (edge_open) begin
                    // A low edge latches B and arms the half step.
                    if (!r_armed && !i_event.a_level) begin
                        n_latch_b = i_event.b_level;
                        n_armed   = 1'b1;
                    end
                    // A high edge completes the detent when B moved consistently.
                    if (r_armed && i_event.a_level) begin
                        if (r_latch_b && !i_event.b_level) begin
                            n_count = r_count + COUNT_W'(1);
                            n_last  = i_event.now_ms;
                            dir     = DIR_UP;
                        end else if (!r_latch_b && i_event.b_level) begin
                            n_count = r_count - COUNT_W'(1);
                            n_last  = i_event.now_ms;
                            dir     = DIR_DOWN;
                        end
                        n_armed = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result reflects the state after this event.
    always_comb begin
        o_result.position   = POS_W'(n_count);
        o_result.step_dir   = dir;
        o_result.menu_index = n_menu;
        o_result.running    = n_run;
    end

    // State registers update once per committed event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_latch_b <= 1'b0;
            r_count   <= '0;
            r_last    <= '0;
            r_menu    <= 2'd0;
            r_run     <= 1'b1;
        end else if (i_commit) begin
            r_armed   <= n_armed;
            r_latch_b <= n_latch_b;
            r_count   <= n_count;
            r_last    <= n_last;
            r_menu    <= n_menu;
            r_run     <= n_run;
        end
    end

endmodule

>>> hw/rtl/rotary_encoder_panel_decoder_unit.sv
// Top level of the rotary encoder panel decoder: input, result and lockout registers.
// Usage:
//   i_in carries one panel event per transfer: opcode (menu press, push button
//   press or encoder A edge), the sampled A and B levels and a millisecond
//   timestamp. o_out returns exactly one result per event: the position after
//   the event, the step direction, the menu index and the run flag.
//   i_cfg writes the 10-bit lockout time in milliseconds; write it only while
//   no event is in flight. It is always ready.
// Timing:
//   An event is captured in the input register, processed by one pass of
//   compare, subtract and small updates, and lands in the result register.
//   One event is taken every cycle while the result register is free or
//   draining; rep_core commits its state update once for each event that
//   moves on.
// Reset:
//   Synchronous, active low. Position, menu index and half-step state clear,
//   the run flag sets, the last count time clears and the lockout returns to
//   50 ms. Both pipeline registers empty.
// Stalls:
//   While o_out is held off, the result register keeps its item and the input
//   register can still take one more event; i_in.ready then drops.
module rotary_encoder_panel_decoder_unit import rep_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rep_in_if.sink    i_in,
    rep_out_if.source o_out,
    rep_cfg_if.sink   i_cfg
);

    logic                 r_in_vld;
    t_event               r_event;
    logic                 r_out_vld;
    t_result              r_result;
    logic [LOCKOUT_W-1:0] r_lockout;
    t_result              core_result;
    logic                 advance;
    logic                 in_take;

    // The held event moves on when the result register is free or draining.
    assign advance     = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_in_vld || advance;
    assign in_take     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_event.opcode  <= i_in.opcode;
            r_event.a_level <= i_in.a_level;
            r_event.b_level <= i_in.b_level;
            r_event.now_ms  <= i_in.now_ms;
        end
    end

    // Lockout configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout <= LOCKOUT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_lockout <= i_cfg.data;
        end
    end

    rep_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (advance),
        .i_event      (r_event),
        .i_lockout_ms (r_lockout),
        .o_result     (core_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.position   = r_result.position;
    assign o_out.step_dir   = r_result.step_dir;
    assign o_out.menu_index = r_result.menu_index;
    assign o_out.running    = r_result.running;

endmodule
